[design/svf_highpass_lowpass_bell_chain_defines.svh]
// Assertion macros shared by the filter cascade RTL.
`ifndef SVF_HIGHPASS_LOWPASS_BELL_CHAIN_DEFINES_SVH
`define SVF_HIGHPASS_LOWPASS_BELL_CHAIN_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SVFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svfc assertion failed");

// Check that cons holds in the cycle after ante.
`define SVFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svfc assertion failed");

`endif

[design/svfc_pkg.sv]
// Shared constants, types and helper functions of the filter cascade.
`timescale 1ns / 1ps
`default_nettype none

package svfc_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SEC_W        = 2;
  localparam int ADDR_W       = SEC_W + CH_W;
  localparam int MEM_DEPTH    = 1 << ADDR_W;
  localparam int SAMPLE_W     = 24;
  localparam int REG_W        = 64;
  localparam int NUM_REGS     = 6;
  localparam int REG_IDX_W    = 3;
  localparam int SAT_IN_W     = 41;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_HP_A1_A2    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HP_A3_DAMP  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LP_A1_A2    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LP_A3_WET   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PK_A1_A2    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PK_A3_BOOST = 3'd5;

  typedef enum logic [SEC_W-1:0] {
    SEC_HP,
    SEC_LP,
    SEC_PK
  } sec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_LD,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_W1,
    S_W2,
    S_WB,
    S_PI,
    S_PW,
    S_PF,
    S_DONE
  } state_t;

  // Request to the integrator state memory
  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [ADDR_W-1:0]  addr;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
  } mem_req_t;

  // Coefficients of the active section
  typedef struct packed {
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] a3;
    logic signed [31:0] post;
  } coef_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    if (v > 41'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -41'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

endpackage

`default_nettype wire

[design/svfc_coef.sv]
// Coefficient register file with per-section coefficient selection.
`timescale 1ns / 1ps
`default_nettype none

module svfc_coef
  import svfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0] cfg_addr,
  input  wire logic [REG_W-1:0]     cfg_wdata,
  input  wire sec_t                 sec,
  output coef_t                     coef
);

  logic [REG_W-1:0] reg_r [NUM_REGS];

  // Store writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_r[i] <= '0;
      end
    end else if (cfg_wr_en && (int'(cfg_addr) < NUM_REGS)) begin
      reg_r[cfg_addr] <= cfg_wdata;
    end
  end

  // Pick the coefficient pair registers of the active section
  always_comb begin
    unique case (sec)
      SEC_HP: begin
        coef.a1   = $signed(reg_r[REG_HP_A1_A2][63:32]);
        coef.a2   = $signed(reg_r[REG_HP_A1_A2][31:0]);
        coef.a3   = $signed(reg_r[REG_HP_A3_DAMP][63:32]);
        coef.post = $signed(reg_r[REG_HP_A3_DAMP][31:0]);
      end
      SEC_LP: begin
        coef.a1   = $signed(reg_r[REG_LP_A1_A2][63:32]);
        coef.a2   = $signed(reg_r[REG_LP_A1_A2][31:0]);
        coef.a3   = $signed(reg_r[REG_LP_A3_WET][63:32]);
        coef.post = $signed(reg_r[REG_LP_A3_WET][31:0]);
      end
      SEC_PK: begin
        coef.a1   = $signed(reg_r[REG_PK_A1_A2][63:32]);
        coef.a2   = $signed(reg_r[REG_PK_A1_A2][31:0]);
        coef.a3   = $signed(reg_r[REG_PK_A3_BOOST][63:32]);
        coef.post = $signed(reg_r[REG_PK_A3_BOOST][31:0]);
      end
      default: begin
        coef = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/svfc_state_mem.sv]
// Integrator state memory: one entry of two states per section and channel.
`timescale 1ns / 1ps
`default_nettype none

module svfc_state_mem
  import svfc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire mem_req_t     req,
  output logic signed [31:0] rd_c1,
  output logic signed [31:0] rd_c2
);

  logic [63:0]          mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid_r;
  logic [63:0]          rdata_r;
  logic                 rvalid_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= {req.c1, req.c2};
    end
    if (req.rd) begin
      rdata_r  <= mem[req.addr];
      rvalid_r <= valid_r[req.addr];
    end
  end

  // Mark entries written since reset; others read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  assign rd_c1 = rvalid_r ? $signed(rdata_r[63:32]) : 32'sd0;
  assign rd_c2 = rvalid_r ? $signed(rdata_r[31:0])  : 32'sd0;

endmodule

`default_nettype wire

[design/svfc_mul.sv]
// Shared Q8.24 multiplier: registered product, then registered round and clamp.
`timescale 1ns / 1ps
`default_nettype none

module svfc_mul
  import svfc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic signed [31:0]  op_a,
  input  wire logic signed [31:0]  op_b,
  output logic signed [31:0]       m
);

  logic signed [63:0] p_r;
  logic signed [64:0] rnd;
  logic signed [31:0] m_r;

  // Round half up at bit 23, keep the floor of the shift by 24
  assign rnd = $signed({p_r[63], p_r}) + 65'sd8388608;

  always_ff @(posedge clk) begin
    p_r <= op_a * op_b;
    m_r <= sat32($signed(rnd[64:24]));
  end

  assign m = m_r;

endmodule

`default_nettype wire

[design/svf_highpass_lowpass_bell_chain.sv]
// Top level of the three-section state variable filter cascade.
`timescale 1ns / 1ps
`default_nettype none
`include "svf_highpass_lowpass_bell_chain_defines.svh"

// High-pass, wet-mixed low-pass and bell sections in series, trapezoidal SVF
// form, Q8.24 inside, Q1.23 at the ports. Each section reads its two
// integrator states for the item's channel from a state memory with a
// registered read port, runs five products through one shared two-stage
// multiplier, writes the states back and hands its output on. A result turns
// valid once the three sections have run and the output register is loaded,
// and a new item is taken only after that, once the result sits in the
// output register; a result not yet taken by out_tready holds the block.
// A channel index at or above NUM_CHANNELS passes its sample through
// unchanged into the output register, without touching state.
// Coefficients are written through cfg_* while the block is idle; register i
// of the list (hp_a1_a2, hp_a3_damp, lp_a1_a2, lp_a3_wet, pk_a1_a2,
// pk_a3_boost) has index i, upper half first coefficient, lower half second,
// both Q8.24.
module svf_highpass_lowpass_bell_chain
  import svfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [23:0]          in_tdata,   // [23:0] sample_in
  input  wire logic [0:0]           in_tuser,   // [0] chan
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [23:0]               out_tdata,  // [23:0] sample_out
  output logic [0:0]                out_tuser,  // [0] chan_out
  input  wire logic                 cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0] cfg_addr,
  input  wire logic [REG_W-1:0]     cfg_wdata
);

  state_t              state_r, state_nxt;
  sec_t                sec_r;
  logic                pass_r;
  logic [0:0]          chan_r;
  logic [CH_W-1:0]     ch_idx_r;
  logic [23:0]         raw_r;
  logic signed [31:0]  y_r, c1_r, c2_r, v3_r, v1_r, v2_r, acc1_r;
  logic signed [32:0]  acc2_r;
  logic signed [33:0]  t_r;
  logic                out_tvalid_r;
  logic [23:0]         out_tdata_r;
  logic [0:0]          out_tuser_r;

  coef_t               coef;
  mem_req_t            mem_req;
  logic signed [31:0]  rd_c1, rd_c2;
  logic signed [31:0]  op_a, op_b, m;
  logic                accept, out_free, pass_in;
  logic signed [31:0]  x_in;
  logic signed [33:0]  e_v3, e_c1, e_c2, e_t_lp, e_y_hp, e_y_add;
  logic signed [32:0]  half;
  logic [23:0]         y_conv;

  svfc_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sec       (sec_r),
    .coef      (coef)
  );

  svfc_state_mem u_state_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rd_c1 (rd_c1),
    .rd_c2 (rd_c2)
  );

  svfc_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .m    (m)
  );

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign pass_in  = int'(in_tuser[0]) >= NUM_CHANNELS;
  assign x_in     = $signed({{7{in_tdata[23]}}, in_tdata, 1'b0});

  // Wide intermediate sums, clamped once where they land
  assign e_v3    = 34'(y_r) - 34'(rd_c2);
  assign e_c1    = (34'(v1_r) <<< 1) - 34'(c1_r);
  assign e_c2    = (34'(v2_r) <<< 1) - 34'(c2_r);
  assign e_t_lp  = 34'(sat32(SAT_IN_W'(34'(v2_r) - 34'(y_r))));
  assign e_y_hp  = t_r - 34'(m);
  assign e_y_add = 34'(y_r) + 34'(m);

  // Convert back to Q1.23 with round half up and clamp
  assign half = (33'(y_r) + 33'sd1) >>> 1;
  always_comb begin
    if (half > 33'sd8388607) begin
      y_conv = 24'h7F_FFFF;
    end else if (half < -33'sd8388608) begin
      y_conv = 24'h80_0000;
    end else begin
      y_conv = half[23:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = pass_in ? S_DONE : S_RD;
      S_RD:   state_nxt = S_LD;
      S_LD:   state_nxt = S_M0;
      S_M0:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_W1;
      S_W1:   state_nxt = S_W2;
      S_W2:   state_nxt = S_WB;
      S_WB:   state_nxt = S_PI;
      S_PI:   state_nxt = S_PW;
      S_PW:   state_nxt = S_PF;
      S_PF:   state_nxt = (sec_r == SEC_PK) ? S_DONE : S_RD;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake, memory requests and multiplier operands
  always_comb begin
    in_tready    = 1'b0;
    mem_req.rd   = 1'b0;
    mem_req.wr   = 1'b0;
    mem_req.addr = {sec_r, ch_idx_r};
    mem_req.c1   = sat32(SAT_IN_W'(e_c1));
    mem_req.c2   = sat32(SAT_IN_W'(e_c2));
    op_a         = 32'sd0;
    op_b         = 32'sd0;
    unique case (state_r)
      S_IDLE: in_tready = rst_n;
      S_RD:   mem_req.rd = 1'b1;
      S_M0: begin
        op_a = coef.a1;
        op_b = c1_r;
      end
      S_M1: begin
        op_a = coef.a2;
        op_b = c1_r;
      end
      S_M2: begin
        op_a = coef.a2;
        op_b = v3_r;
      end
      S_M3: begin
        op_a = coef.a3;
        op_b = v3_r;
      end
      S_WB:   mem_req.wr = 1'b1;
      S_PI: begin
        op_a = coef.post;
        op_b = (sec_r == SEC_LP) ? $signed(t_r[31:0]) : v1_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sec_r        <= SEC_HP;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        sec_r <= SEC_HP;
      end else if (state_r == S_PF) begin
        unique case (sec_r)
          SEC_HP:  sec_r <= SEC_LP;
          SEC_LP:  sec_r <= SEC_PK;
          default: sec_r <= sec_r;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          chan_r   <= in_tuser;
          ch_idx_r <= CH_W'(in_tuser[0]);
          raw_r    <= in_tdata;
          pass_r   <= pass_in;
          y_r      <= x_in;
        end
      end
      S_LD: begin
        c1_r <= rd_c1;
        c2_r <= rd_c2;
        v3_r <= sat32(SAT_IN_W'(e_v3));
      end
      S_M2:   acc1_r <= m;
      S_M3:   acc2_r <= 33'(c2_r) + 33'(m);
      S_W1:   v1_r   <= sat32(SAT_IN_W'(34'(acc1_r) + 34'(m)));
      S_W2:   v2_r   <= sat32(SAT_IN_W'(34'(acc2_r) + 34'(m)));
      S_WB: begin
        unique case (sec_r)
          SEC_HP:  t_r <= 34'(y_r) - 34'(v2_r);
          SEC_LP:  t_r <= e_t_lp;
          default: t_r <= 34'(y_r);
        endcase
      end
      S_PF: begin
        if (sec_r == SEC_HP) begin
          y_r <= sat32(SAT_IN_W'(e_y_hp));
        end else begin
          y_r <= sat32(SAT_IN_W'(e_y_add));
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_tuser_r <= chan_r;
          out_tdata_r <= pass_r ? raw_r : y_conv;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Pass-through items never reach the state memory
  `SVFC_ASSERT_NOW(a_pass_no_read, state_r == S_RD, !pass_r)
  // A waiting result is never overwritten
  `SVFC_ASSERT_NEXT(a_out_held, state_r == S_DONE && out_tvalid_r && !out_tready,
                    out_tvalid_r && $stable(out_tdata_r) && $stable(out_tuser_r))
  // Write-back in S_WB follows the matching read in S_RD, through S_LD, S_M0 to S_M3, S_W1 and S_W2
  `SVFC_ASSERT_NOW(a_wb_after_rd, mem_req.wr, $past(state_r, 8) == S_RD)

endmodule

`default_nettype wire
